/* rtl/mts_pkg.sv */
// Shared types and constants for the modular Taylor shift block.
// No dependencies; used by mts_engine, modular_taylor_shift_top and the testbench.
package mts_pkg;

    localparam int COEFF_BITS = 32;
    localparam int MAX_LEN    = 64;
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int STEP_W     = $clog2(COEFF_BITS + 1);

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_SHIFT   = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD, ST_LRED, ST_FIN, ST_RRD, ST_RGO, ST_RWT, ST_CGO, ST_CWT,
        ST_HA, ST_HB, ST_HGO, ST_HWT, ST_ORD, ST_OV
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [COEFF_BITS-1:0] a;
        logic [COEFF_BITS-1:0] y;
        logic [COEFF_BITS-1:0] addend;
    } t_eng_req;

    typedef struct packed {
        logic                  done;
        logic [COEFF_BITS-1:0] result;
    } t_eng_rsp;

endpackage

/* rtl/mts_engine.sv */
// Bit-serial modular multiply-add: result = (addend + a * y) mod m.
// Needs a < m, addend < m, m >= 2. Depends on mts_pkg.
module mts_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mts_pkg::t_eng_req              i_req,
    input  logic [mts_pkg::COEFF_BITS-1:0] i_m,
    output mts_pkg::t_eng_rsp              o_rsp
);
    import mts_pkg::*;

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [COEFF_BITS-1:0] r_acc, r_a, r_y, r_add;
    logic                  r_done;
    logic [COEFF_BITS:0]   dbl, dbl_red, sum, sum_red, fin;
    logic [COEFF_BITS-1:0] n_acc;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        sum     = dbl_red + (r_y[COEFF_BITS-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= {1'b0, i_m}) ? sum - {1'b0, i_m} : sum;
        fin     = {1'b0, r_acc} + {1'b0, r_add};
        if (fin >= {1'b0, i_m}) begin
            fin = fin - {1'b0, i_m};
        end
        n_acc = (r_step == STEP_W'(COEFF_BITS)) ? fin[COEFF_BITS-1:0]
                                               : sum_red[COEFF_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_acc  <= '0;
                r_a    <= i_req.a;
                r_y    <= i_req.y;
                r_add  <= i_req.addend;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_y    <= {r_y[COEFF_BITS-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(COEFF_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

/* rtl/modular_taylor_shift_top.sv */
// Top level of the modular Taylor shift block: sequencer and coefficient store.
// Depends on mts_pkg and mts_engine.
//
// Coefficients arrive lowest degree first; each stored item is reduced by the
// shared bit-serial engine before the next is taken. On the last item every
// stored coefficient is reduced again, the shift is reduced, and, unless the
// reduced shift is zero or n < 2, the Horner pass runs (n-1)*n/2 multiply-adds
// in that one engine. Results then leave one at a time, each held until taken
// (i_m_tready). At most 64 coefficients are kept; further ones set the overflow
// flag carried in tuser of every result of that run.
module modular_taylor_shift_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // in_coeff
    input  logic        i_s_tlast,   // in_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // out_coeff
    output logic        o_m_tlast,   // out_last
    output logic        o_m_tuser    // overflow
);
    import mts_pkg::*;

    t_state                r_state, n_state;
    logic [COEFF_BITS-1:0] r_mod, r_shift, r_c, r_opa, r_rdata;
    logic [LEN_W-1:0]      r_len;
    logic                  r_trunc, r_last;
    logic [IDX_W-1:0]      r_i, r_j;
    logic [COEFF_BITS-1:0] mem [MAX_LEN];

    t_eng_req              req;
    t_eng_rsp              rsp;
    logic [COEFF_BITS-1:0] m_eff, res;
    logic                  unit, we, j_end, h_end;
    logic [IDX_W-1:0]      raddr, waddr;

    assign unit  = (r_mod < COEFF_BITS'(2));
    assign m_eff = unit ? COEFF_BITS'(2) : r_mod;
    assign res   = unit ? '0 : rsp.result;
    assign j_end = ({1'b0, r_j} == r_len - 1'b1);
    assign h_end = ({1'b0, r_j} == r_len - LEN_W'(2));

    mts_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_m     (m_eff),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (i_s_tvalid) begin
                if (r_len < LEN_W'(MAX_LEN)) begin
                    n_state = ST_LRED;
                end else if (i_s_tlast) begin
                    n_state = ST_FIN;
                end
            end
            ST_LRED: if (rsp.done) n_state = r_last ? ST_FIN : ST_LOAD;
            ST_FIN:  n_state = ST_RRD;
            ST_RRD:  n_state = ST_RGO;
            ST_RGO:  n_state = ST_RWT;
            ST_RWT:  if (rsp.done) n_state = j_end ? ST_CGO : ST_RRD;
            ST_CGO:  n_state = ST_CWT;
            ST_CWT:  if (rsp.done) begin
                n_state = (res == '0 || r_len < LEN_W'(2)) ? ST_ORD : ST_HA;
            end
            ST_HA:   n_state = ST_HB;
            ST_HB:   n_state = ST_HGO;
            ST_HGO:  n_state = ST_HWT;
            ST_HWT:  if (rsp.done) n_state = (h_end && r_i == '0) ? ST_ORD : ST_HA;
            ST_ORD:  n_state = ST_OV;
            ST_OV:   if (i_m_tready) n_state = j_end ? ST_LOAD : ST_ORD;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        req        = '0;
        raddr      = r_j;
        waddr      = r_j;
        we         = 1'b0;
        o_s_tready = (r_state == ST_LOAD);
        o_m_tvalid = (r_state == ST_OV);
        unique case (r_state)
            ST_LOAD: begin
                req.start = i_s_tvalid && (r_len < LEN_W'(MAX_LEN));
                req.a     = COEFF_BITS'(1);
                req.y     = i_s_tdata;
            end
            ST_LRED: begin
                waddr = r_len[IDX_W-1:0];
                we    = rsp.done;
            end
            ST_RGO: begin
                req.start = 1'b1;
                req.a     = COEFF_BITS'(1);
                req.y     = r_rdata;
            end
            ST_RWT: we = rsp.done;
            ST_CGO: begin
                req.start = 1'b1;
                req.a     = COEFF_BITS'(1);
                req.y     = r_shift;
            end
            ST_HA:  raddr = r_j + 1'b1;
            ST_HGO: begin
                req.start  = 1'b1;
                req.a      = r_opa;
                req.y      = r_c;
                req.addend = r_rdata;
            end
            ST_HWT: we = rsp.done;
            default: ;
        endcase
    end

    assign o_m_tdata = r_rdata;
    assign o_m_tlast = j_end;
    assign o_m_tuser = r_trunc;

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[raddr];
        if (we) begin
            mem[waddr] <= res;
        end
        if (r_state == ST_HB) begin
            r_opa <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_mod   <= COEFF_BITS'(2);
            r_shift <= '0;
            r_len   <= '0;
            r_trunc <= 1'b0;
            r_last  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_MODULUS) begin
                    r_mod <= i_cfg_wdata;
                end else if (i_cfg_addr == REG_SHIFT) begin
                    r_shift <= i_cfg_wdata;
                end
            end
            unique case (r_state)
                ST_LOAD: if (i_s_tvalid) begin
                    r_last <= i_s_tlast;
                    if (r_len >= LEN_W'(MAX_LEN)) begin
                        r_trunc <= 1'b1;
                    end
                end
                ST_LRED: if (rsp.done) r_len <= r_len + 1'b1;
                ST_FIN:  r_j <= '0;
                ST_RWT:  if (rsp.done && !j_end) r_j <= r_j + 1'b1;
                ST_CWT:  if (rsp.done) begin
                    r_c <= res;
                    r_i <= IDX_W'(r_len - LEN_W'(2));
                    r_j <= (res == '0 || r_len < LEN_W'(2)) ? '0
                                                            : IDX_W'(r_len - LEN_W'(2));
                end
                ST_HWT: if (rsp.done) begin
                    if (h_end) begin
                        if (r_i == '0) begin
                            r_j <= '0;
                        end else begin
                            r_i <= r_i - 1'b1;
                            r_j <= r_i - 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_OV: if (i_m_tready) begin
                    if (j_end) begin
                        r_len   <= '0;
                        r_trunc <= 1'b0;
                        r_j     <= '0;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for modular_taylor_shift_top: drives coefficient runs and
// register settings, predicts f(x+c) mod m and checks every result item.
// Depends on mts_pkg and the RTL of the block.
module testbench;
    import mts_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DEPTH = 64;

    typedef struct {
        bit [31:0] coeff;
        bit        last;
        bit        ovf;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = REG_MODULUS;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    modular_taylor_shift_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the shifter.
    bit [31:0] shadow_coeffs [DEPTH];
    int        shadow_len = 0;
    bit        shadow_trunc = 1'b0;
    bit [31:0] shadow_modulus = 32'd2;
    bit [31:0] shadow_shift = 32'd0;

    t_result   pending_results[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        hold_req = 0;
    int        hold_left = 0;
    int        stall_mode = 0;
    int        cycle_count = 0;

    function automatic bit [31:0] mul_add_mod(bit [31:0] acc, bit [31:0] a, bit [31:0] b,
                                              bit [63:0] m);
        bit [63:0] prod;
        prod = ({32'd0, a} * {32'd0, b}) % m;
        return 32'(({32'd0, acc} + prod) % m);
    endfunction

    task automatic shift_predict(bit [31:0] coeff, bit last);
        bit        unit;
        bit [63:0] m;
        bit [31:0] c;
        t_result   r;
        unit = shadow_modulus < 2;
        m = unit ? 64'd2 : {32'd0, shadow_modulus};
        if (shadow_len < DEPTH) begin
            shadow_coeffs[shadow_len] = unit ? 32'd0 : 32'({32'd0, coeff} % m);
            shadow_len++;
        end else begin
            shadow_trunc = 1'b1;
        end
        if (!last) return;
        c = unit ? 32'd0 : 32'({32'd0, shadow_shift} % m);
        for (int j = 0; j < shadow_len; j++)
            shadow_coeffs[j] = unit ? 32'd0 : 32'({32'd0, shadow_coeffs[j]} % m);
        if (c != 0 && shadow_len >= 2) begin
            for (int i = shadow_len - 2; i >= 0; i--)
                for (int j = i; j + 1 < shadow_len; j++)
                    shadow_coeffs[j] = mul_add_mod(shadow_coeffs[j], shadow_coeffs[j+1], c, m);
        end
        for (int j = 0; j < shadow_len; j++) begin
            r.coeff = shadow_coeffs[j];
            r.last  = (j + 1 == shadow_len);
            r.ovf   = shadow_trunc;
            pending_results.push_back(r);
        end
        shadow_len = 0;
        shadow_trunc = 1'b0;
    endtask

    task automatic send_item(bit [31:0] coeff, bit last);
        bit ready_seen;
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= coeff;
        i_s_tlast  <= last;
        forever begin
            @(negedge i_clk);
            ready_seen = o_s_tready;
            @(posedge i_clk);
            if (ready_seen) break;
        end
        burst_left--;
        items_sent++;
        shift_predict(coeff, last);
    endtask

    task automatic send_run(int len);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0: send_item(32'd0, k == len - 1);
                1: send_item(32'hFFFF_FFFF, k == len - 1);
                default: send_item($urandom, k == len - 1);
            endcase
        end
    endtask

    // Called right after an accepted item or while already idle.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, bit [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == REG_MODULUS) shadow_modulus = value;
        else shadow_shift = value;
    endtask

    task automatic configure(bit [31:0] modulus, bit [31:0] shift);
        wait_drained();
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_SHIFT, shift);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(32'd7, 1'b1);
        configure(32'hFFFF_FFFF, 32'd1);
        send_item(32'd0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'd5, 1'b1);
        configure(32'd0, 32'd3);
        send_run(3);
        configure(32'd1, 32'hFFFF_FFFF);
        send_run(2);
        configure(32'd13, 32'd12);
        send_run(5);
        configure(32'd97, 32'd1000);
        send_run(4);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b1);
        configure(32'd2, 32'd0);
        send_run(3);
    endtask

    task automatic test_random();
        int runs;
        runs = 0;
        while (items_sent < 180) begin
            if (runs % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0: configure($urandom_range(2, 20), $urandom);
                    1: configure(32'hFFFF_FFFF, $urandom);
                    2: configure($urandom, $urandom_range(0, 3));
                    3: configure($urandom_range(0, 1), $urandom);
                    default: configure($urandom, $urandom);
                endcase
            end
            send_run($urandom_range(1, 8));
            runs++;
        end
    endtask

    task automatic test_backpressure();
        configure($urandom, $urandom);
        hold_req = 3000;
        for (int k = 0; k < 8; k++) send_run(3);
        wait_drained();
    endtask

    task automatic test_overflow();
        configure($urandom | 32'h8000_0000, $urandom);
        send_run(DEPTH + 2);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (cycle_count % 200 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= $urandom_range(0, 1);
                default: i_m_tready <= (cycle_count % 4 == 0);
            endcase
        end
    end

    always @(negedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: coeff=%h last=%b ovf=%b",
                             o_m_tdata, o_m_tlast, o_m_tuser);
            end else begin
                e = pending_results.pop_front();
                if (o_m_tdata !== e.coeff || o_m_tlast !== e.last || o_m_tuser !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected coeff=%h last=%b ovf=%b, got %h %b %b",
                                 e.coeff, e.last, e.ovf, o_m_tdata, o_m_tlast, o_m_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_overflow();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* modular_taylor_shift_top.f */
rtl/mts_pkg.sv
rtl/mts_engine.sv
rtl/modular_taylor_shift_top.sv
bench/testbench.sv
